// ----- design/pdp_pkg.sv -----
`default_nettype none
package pdp_pkg;
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam logic [36:0] RATE_RESET = 37'd12500000;
    localparam logic [29:0] NS_IN_SEC = 30'd1000000000;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] MIN_IPV4_LEN = 16'd34;
    localparam logic [2:0] OUT_NOT_IPV4 = 3'd0;
    localparam logic [2:0] OUT_NEW_FLOW = 3'd1;
    localparam logic [2:0] OUT_TABLE_FULL = 3'd2;
    localparam logic [2:0] OUT_IDLE = 3'd3;
    localparam logic [2:0] OUT_BACKLOG = 3'd4;

    typedef struct packed {
        logic [63:0] now_ns;
        logic [15:0] captured_len;
        logic [15:0] ether_type;
        logic [31:0] dest_addr;
        logic [15:0] pkt_len;
    } pkt_in_t;

    typedef struct packed {
        logic        stamp_valid;
        logic [63:0] departure_ns;
        logic [2:0]  outcome;
    } pkt_out_t;
endpackage
`default_nettype wire

// ----- design/per_destination_departure_pacer.sv -----
// channel | ports                  | handshake
// cmd     | start, busy, cmd       | taken when start && !busy
// result  | result_valid, result   | one cycle strobe, cannot stall
// config  | cfg_we, cfg_wdata      | written when cfg_we
// Non-IPv4 words: result the cycle after acceptance, busy stays low.
// Lookup: busy while the table is scanned entry by entry and then decided; the result shows as busy drops.
// Hits add a serial division and a write-back state before the result.
// Reset clears valid bits and restores the default rate; tables are memories without reset.
`default_nettype none
module per_destination_departure_pacer #(
    parameter int TABLE_ENTRIES = pdp_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire pdp_pkg::pkt_in_t  cmd,
    output logic                   result_valid,
    output pdp_pkg::pkt_out_t      result,
    input  wire logic              cfg_we,
    input  wire logic [36:0]       cfg_wdata
);
    import pdp_pkg::*;
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DECIDE = 3'd2,
                           S_DIV = 3'd3, S_WB = 3'd4;

    logic [2:0]  state_reg;
    logic [36:0] rate_reg;
    pkt_in_t     in_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [CW-1:0] idx_reg;
    logic        hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic        rd_pend_reg;
    logic [IW-1:0] rd_idx_reg;

    logic [31:0] key_mem [TABLE_ENTRIES];
    logic [63:0] nf_mem [TABLE_ENTRIES];
    logic [31:0] key_q;
    logic [63:0] nf_q;
    logic [63:0] stored_reg;

    logic        div_go, div_done;
    logic [45:0] div_q;
    logic [36:0] rate_eff;
    logic [45:0] product;

    logic        free_found;
    logic [IW-1:0] free_idx;

    assign busy = (state_reg != S_IDLE);
    assign rate_eff = (rate_reg == '0) ? 37'd1 : rate_reg;
    assign product = {30'd0, in_reg.pkt_len} * {16'd0, NS_IN_SEC};

    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_q <= key_mem[idx_reg[IW-1:0]];
        nf_q  <= nf_mem[hit_idx_reg];
        if (state_reg == S_DECIDE && !hit_reg && free_found)
        begin
            key_mem[free_idx] <= in_reg.dest_addr;
            nf_mem[free_idx]  <= in_reg.now_ns;
        end
        if (state_reg == S_WB)
        begin
            nf_mem[hit_idx_reg] <= ((stored_reg < in_reg.now_ns) ? in_reg.now_ns
                                    : stored_reg) + {18'd0, div_q};
        end
    end

    pdp_divider u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(product),
        .divisor(rate_eff), .done(div_done), .quotient(div_q)
    );

    assign div_go = (state_reg == S_DECIDE) && hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rate_reg <= RATE_RESET;
            valid_reg <= '0;
            result_valid <= 1'b0;
            idx_reg <= '0;
            hit_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_we)
            begin
                rate_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        in_reg <= cmd;
                        if (cmd.captured_len < MIN_IPV4_LEN || cmd.ether_type != ETYPE_IPV4)
                        begin
                            result_valid <= 1'b1;
                            result <= '{1'b0, 64'd0, OUT_NOT_IPV4};
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                            idx_reg <= '0;
                            hit_reg <= 1'b0;
                            rd_pend_reg <= 1'b0;
                        end
                    end
                end
                S_SCAN:
                begin
                    rd_pend_reg <= (idx_reg < CW'(TABLE_ENTRIES));
                    rd_idx_reg <= idx_reg[IW-1:0];
                    if (rd_pend_reg && !hit_reg && valid_reg[rd_idx_reg]
                        && key_q == in_reg.dest_addr)
                    begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                    end
                    if (idx_reg < CW'(TABLE_ENTRIES))
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                    else
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (hit_reg)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        result_valid <= 1'b1;
                        if (free_found)
                        begin
                            valid_reg[free_idx] <= 1'b1;
                            result <= '{1'b0, 64'd0, OUT_NEW_FLOW};
                        end
                        else
                        begin
                            result <= '{1'b0, 64'd0, OUT_TABLE_FULL};
                        end
                    end
                end
                S_DIV:
                begin
                    stored_reg <= nf_q;
                    if (div_done)
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    state_reg <= S_IDLE;
                    result_valid <= 1'b1;
                    if (stored_reg < in_reg.now_ns)
                    begin
                        result <= '{1'b1, in_reg.now_ns, OUT_IDLE};
                    end
                    else
                    begin
                        result <= '{1'b1, stored_reg, OUT_BACKLOG};
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/pdp_divider.sv -----
`default_nettype none
module pdp_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [45:0] dividend,
    input  wire logic [36:0] divisor,
    output logic             done,
    output logic [45:0]      quotient
);
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic [45:0] q_reg;
    logic [37:0] r_reg;
    logic [36:0] d_reg;
    logic [37:0] trial;

    assign trial = {r_reg[36:0], q_reg[45]};
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 6'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd45)
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_reg <= trial - {1'b0, d_reg};
                q_reg <= {q_reg[44:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[44:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/pdp_checker.sv -----
`default_nettype none
module pdp_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              result_valid,
    input wire pdp_pkg::pkt_out_t result
);
    import pdp_pkg::*;
    a_unstamped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.stamp_valid |-> result.departure_ns == 64'd0)
        else $error("unstamped word has nonzero departure");
    a_stamp_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.stamp_valid ==
            (result.outcome == OUT_IDLE || result.outcome == OUT_BACKLOG))
        else $error("stamp and outcome disagree");
    a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result while busy");
    a_take_gives_activity: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || result_valid)
        else $error("word taken with no effect");
endmodule
bind per_destination_departure_pacer pdp_checker u_pdp_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .result_valid(result_valid), .result(result)
);
`default_nettype wire

// ----- test/per_destination_departure_pacer_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
module per_destination_departure_pacer_test;
    import pdp_pkg::*;

    localparam int SLOTS = 16;

    class departure_board;
        bit          slot_used [SLOTS];
        logic [31:0] slot_addr [SLOTS];
        logic [63:0] slot_free [SLOTS];
        logic [36:0] rate;
        pkt_out_t    pending [$];
        int          errors;
        int          seen [8];

        function void clear();
            for (int i = 0; i < SLOTS; i++) slot_used[i] = 0;
            rate = RATE_RESET;
            errors = 0;
        endfunction

        function void note_packet(pkt_in_t p);
            pkt_out_t r;
            int hit;
            int spare;
            logic [63:0] r_eff;
            logic [63:0] gap;
            hit = -1;
            spare = -1;
            r = '0;
            if (p.ether_type != ETYPE_IPV4 || p.captured_len < MIN_IPV4_LEN) begin
                r.outcome = OUT_NOT_IPV4;
            end else begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i]) begin
                        if (hit < 0 && slot_addr[i] == p.dest_addr) hit = i;
                    end else if (spare < 0) spare = i;
                end
                if (hit < 0) begin
                    if (spare < 0) r.outcome = OUT_TABLE_FULL;
                    else begin
                        slot_used[spare] = 1;
                        slot_addr[spare] = p.dest_addr;
                        slot_free[spare] = p.now_ns;
                        r.outcome = OUT_NEW_FLOW;
                    end
                end else begin
                    r_eff = (rate == 0) ? 64'd1 : {27'd0, rate};
                    gap = ({48'd0, p.pkt_len} * 64'd1000000000) / r_eff;
                    r.stamp_valid = 1;
                    if (slot_free[hit] < p.now_ns) begin
                        r.departure_ns = p.now_ns;
                        r.outcome = OUT_IDLE;
                        slot_free[hit] = p.now_ns + gap;
                    end else begin
                        r.departure_ns = slot_free[hit];
                        r.outcome = OUT_BACKLOG;
                        slot_free[hit] = slot_free[hit] + gap;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(pkt_out_t got);
            pkt_out_t want;
            if (pending.size() == 0) begin
                $display("%0t unexpected word %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            seen[want.outcome]++;
            if (got.stamp_valid !== want.stamp_valid)
                begin $display("%0t stamp_valid exp %0b got %0b", $time,
                    want.stamp_valid, got.stamp_valid); errors++; end
            if (got.departure_ns !== want.departure_ns)
                begin $display("%0t departure_ns exp %0h got %0h", $time,
                    want.departure_ns, got.departure_ns); errors++; end
            if (got.outcome !== want.outcome)
                begin $display("%0t outcome exp %0d got %0d", $time,
                    want.outcome, got.outcome); errors++; end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    pkt_in_t     cmd;
    logic        result_valid;
    pkt_out_t    result;
    logic        cfg_we;
    logic [36:0] cfg_wdata;

    departure_board board;
    logic [31:0] addr_pool [24];
    logic [63:0] clock_ns;

    per_destination_departure_pacer dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .result_valid(result_valid), .result(result),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && result_valid) board.check_result(result);

    task automatic send_packet(pkt_in_t p, bit may_idle);
        int hold;
        hold = may_idle ? $urandom_range(0, 12) : 0;
        if (hold > 0) begin
            start <= 0;
            repeat (hold) @(posedge clk);
        end
        start <= 1;
        cmd <= p;
        do @(posedge clk); while (busy);
        board.note_packet(p);
    endtask

    task automatic drain();
        start <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_rate(logic [36:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        board.rate = v;
    endtask

    function automatic pkt_in_t make_packet(logic [63:0] t, logic [15:0] cap,
        logic [15:0] et, logic [31:0] da, logic [15:0] len);
        pkt_in_t p;
        p.now_ns = t;
        p.captured_len = cap;
        p.ether_type = et;
        p.dest_addr = da;
        p.pkt_len = len;
        return p;
    endfunction

    function automatic pkt_in_t random_packet();
        pkt_in_t p;
        int pick;
        pick = $urandom_range(0, 99);
        clock_ns = clock_ns + (($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 500000))
                                                           : 64'($urandom_range(0, 2000)));
        p.now_ns = clock_ns;
        p.captured_len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 40))
                                                     : 16'($urandom);
        p.ether_type = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETYPE_IPV4;
        p.dest_addr = (pick < 90) ? addr_pool[$urandom_range(0, 23)] : $urandom;
        p.pkt_len = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(40, 1500));
        if (pick == 99) p.now_ns = {$urandom, $urandom};
        return p;
    endfunction

    initial
    begin
        logic [36:0] rates [6];
        board = new();
        board.clear();
        rst_n = 0;
        start = 0;
        cmd = '0;
        cfg_we = 0;
        cfg_wdata = '0;
        clock_ns = 64'd1000;
        rates = '{37'd1, 37'h1F_FFFF_FFFF, 37'd0, 37'd1000000, 37'd125000000, RATE_RESET};
        for (int i = 0; i < 24; i++) addr_pool[i] = $urandom;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_packet(make_packet(64'd0, 16'd0, ETYPE_IPV4, 32'h0a000001, 16'd100), 0);
        send_packet(make_packet(64'd0, 16'd13, ETYPE_IPV4, 32'h0a000001, 16'd100), 0);
        send_packet(make_packet(64'd0, 16'd33, ETYPE_IPV4, 32'h0a000001, 16'd100), 0);
        send_packet(make_packet(64'd0, 16'hFFFF, 16'h86DD, 32'h0a000001, 16'd100), 0);
        send_packet(make_packet(64'd0, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF), 0);
        send_packet(make_packet(64'd100, 16'd34, ETYPE_IPV4, 32'h0a000001, 16'd100), 0);
        send_packet(make_packet(64'd200, 16'd34, ETYPE_IPV4, 32'h0a000001, 16'd1000), 0);
        send_packet(make_packet(64'd300, 16'd34, ETYPE_IPV4, 32'h0a000001, 16'hFFFF), 0);
        send_packet(make_packet(64'hFFFF_FFFF_FFFF_FFF0, 16'hFFFF, ETYPE_IPV4, 32'hFFFFFFFF,
            16'd0), 0);
        send_packet(make_packet(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, ETYPE_IPV4, 32'hFFFFFFFF,
            16'hFFFF), 0);
        send_packet(make_packet(64'd0, 16'd60, ETYPE_IPV4, 32'hFFFFFFFF, 16'd1), 0);
        for (int i = 0; i < 15; i++)
            send_packet(make_packet(64'd5, 16'd60, ETYPE_IPV4, 32'h20000000 + i, 16'd64), 0);
        set_rate(37'd0);
        send_packet(make_packet(64'd500, 16'd60, ETYPE_IPV4, 32'h0a000001, 16'd3), 0);

        rst_n <= 1;
        for (int ph = 0; ph < 6; ph++) begin
            set_rate(rates[ph]);
            for (int n = 0; n < 270; n++) begin
                send_packet(random_packet(), ($urandom_range(0, 3) != 0) && (n > 40));
                if (n == 135 && ph == 2) drain();
            end
        end
        drain();
        $display("Covered %0d not-IPv4, %0d new, %0d full, %0d idle, %0d backlogged words",
            board.seen[OUT_NOT_IPV4], board.seen[OUT_NEW_FLOW], board.seen[OUT_TABLE_FULL],
            board.seen[OUT_IDLE], board.seen[OUT_BACKLOG]);
        $display("over six rate settings including zero and the largest rate.");
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
